FILE: design/lbcd_pkg.sv
// Shared constants and control types for the LRU block cache directory.
package lbcd_pkg;

  // Field widths
  localparam int DEV_W      = 8;
  localparam int BLK_W      = 31;
  localparam int SLOT_W     = 5;
  localparam int SECTOR_W   = 48;
  localparam int STAMP_W    = 32;
  localparam int PSTART_W   = 32;
  localparam int SHIFT_W    = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT     = 1'd1;

  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RESET = 4'd2;

  // Directory size
  localparam int DEFAULT_ENTRIES = 32;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // request transaction taken this cycle
    logic rd;      // read tag/stamp memories at scan address
    logic commit;  // write back entry and load result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } status_t;

endpackage

FILE: design/lbcd_if.sv
// Request and result channel interfaces of the LRU block cache directory.
interface lbcd_req_if;
  import lbcd_pkg::*;

  logic             valid;
  logic             ready;
  logic [DEV_W-1:0] dev_id;
  logic [BLK_W-1:0] block_number;

  modport source (output valid, output dev_id, output block_number, input ready);
  modport sink   (input valid, input dev_id, input block_number, output ready);
endinterface

interface lbcd_rsp_if;
  import lbcd_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [SLOT_W-1:0]   slot;
  logic [SECTOR_W-1:0] fetch_sector;

  modport source (output valid, output hit, output slot, output fetch_sector, input ready);
  modport sink   (input valid, input hit, input slot, input fetch_sector, output ready);
endinterface

FILE: design/lru_block_cache_directory.sv
// A taken request walks every entry (SCAN), then passes DRAIN and COMMIT; COMMIT waits until
//   the result register is free. Each request walks every entry through the single read port
//   of the tag and stamp memories, one entry a cycle; the next request is taken only after commit.
// A new request is taken while the previous result still waits in the output register.
// Reset: valid bits, use counter and device tracking clear at once, config takes its reset
//   values (block shift BLOCK_SHIFT_RESET); no clearing pass, tag and stamp memories are not reset.
module lru_block_cache_directory #(
  parameter int ENTRIES = lbcd_pkg::DEFAULT_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lbcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lbcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lbcd_req_if.sink                        req,
  lbcd_rsp_if.source                      rsp
);
  import lbcd_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] scan_addr;

  // Sequencer
  lbcd_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .cmd_o       (cmd),
    .scan_addr_o (scan_addr),
    .status_i    (status)
  );

  // Directory datapath
  lbcd_datapath #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .dev_id_i       (req.dev_id),
    .block_number_i (req.block_number),
    .cmd_i          (cmd),
    .scan_addr_i    (scan_addr),
    .status_o       (status),
    .rsp            (rsp)
  );

endmodule

FILE: design/lbcd_ctrl.sv
// Sequencer: accepts a request, walks all entries, then commits the result.
module lbcd_ctrl #(
  parameter int ENTRIES = lbcd_pkg::DEFAULT_ENTRIES,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lbcd_req_if.sink            req,
  output lbcd_pkg::cmd_t      cmd_o,
  output logic [IDX_W-1:0]    scan_addr_o,
  input  lbcd_pkg::status_t   status_i
);
  import lbcd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign req.ready = (state_q == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // Next state and scan counter
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o.accept = accept;
    cmd_o.rd     = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign scan_addr_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  // A taken request always starts the walk at entry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && (cnt_q == '0))
    else $error("walk did not start at entry zero");

  // Drain only follows the final scan cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> $past(state_q == ST_SCAN) && ($past(cnt_q) == LAST_IDX))
    else $error("drain entered before the walk finished");

  // State register stays one-hot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");
`endif

endmodule

FILE: design/lbcd_datapath.sv
// Tag/stamp memories, valid bits, compare and LRU search, result register.
module lbcd_datapath #(
  parameter int ENTRIES = lbcd_pkg::DEFAULT_ENTRIES,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lbcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lbcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [lbcd_pkg::DEV_W-1:0]      dev_id_i,
  input  logic [lbcd_pkg::BLK_W-1:0]      block_number_i,
  input  lbcd_pkg::cmd_t                  cmd_i,
  input  logic [IDX_W-1:0]                scan_addr_i,
  output lbcd_pkg::status_t               status_o,
  lbcd_rsp_if.source                      rsp
);
  import lbcd_pkg::*;

  // Configuration registers
  logic [PSTART_W-1:0] pstart_q;
  logic [SHIFT_W-1:0]  shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pstart_q <= '0;
      shift_q  <= BLOCK_SHIFT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PARTITION_START: pstart_q <= cfg_data_i[PSTART_W-1:0];
        REG_BLOCK_SHIFT:     shift_q  <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Directory state
  logic [BLK_W-1:0]   tag_mem   [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [STAMP_W-1:0] use_cnt_q;
  logic [DEV_W-1:0]   cur_dev_q;
  logic               dev_known_q;

  // Current request
  logic [BLK_W-1:0]    blk_q;
  logic [SECTOR_W-1:0] blk_sh_q;

  // Memory read stage
  logic [BLK_W-1:0]   tag_rd_q;
  logic [STAMP_W-1:0] stamp_rd_q;
  logic               rd_v_q;
  logic [IDX_W-1:0]   rd_idx_q;

  // Walk results
  logic               found_q, inv_found_q, min_seen_q;
  logic [IDX_W-1:0]   hit_idx_q, inv_idx_q, min_idx_q;
  logic [STAMP_W-1:0] min_stamp_q;

  // Result register
  logic                out_valid_q;
  logic                out_hit_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [SECTOR_W-1:0] out_sector_q;

  logic               dev_change;
  logic               ent_valid;
  logic               tag_match;
  logic [IDX_W-1:0]   victim_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic [STAMP_W-1:0] stamp_new;

  assign dev_change = !dev_known_q || (dev_id_i != cur_dev_q);
  assign ent_valid  = valid_q[rd_idx_q];
  assign tag_match  = rd_v_q && ent_valid && (tag_rd_q == blk_q);
  assign victim_idx = inv_found_q ? inv_idx_q : min_idx_q;
  assign wr_idx     = found_q ? hit_idx_q : victim_idx;
  assign stamp_new  = use_cnt_q + 1'b1;

  // Device tracking, valid bits and use counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      use_cnt_q   <= '0;
      cur_dev_q   <= '0;
      dev_known_q <= 1'b0;
    end else if (cmd_i.accept) begin
      if (dev_change) begin
        valid_q     <= '0;
        use_cnt_q   <= '0;
        cur_dev_q   <= dev_id_i;
        dev_known_q <= 1'b1;
      end
    end else if (cmd_i.commit) begin
      use_cnt_q       <= stamp_new;
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // Request payload and pre-shifted block number
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      blk_q <= block_number_i;
    end
    blk_sh_q <= SECTOR_W'(blk_q) << shift_q;
  end

  // Tag memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      tag_rd_q <= tag_mem[scan_addr_i];
    end
    if (cmd_i.commit && !found_q) begin
      tag_mem[wr_idx] <= blk_q;
    end
  end

  // Stamp memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      stamp_rd_q <= stamp_mem[scan_addr_i];
    end
    if (cmd_i.commit) begin
      stamp_mem[wr_idx] <= stamp_new;
    end
  end

  // Read stage tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      rd_v_q   <= cmd_i.rd;
      rd_idx_q <= scan_addr_i;
    end
  end

  // Walk: first hit, first empty entry, oldest stamp (lowest index on ties)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      inv_found_q <= 1'b0;
      min_seen_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      found_q     <= 1'b0;
      inv_found_q <= 1'b0;
      min_seen_q  <= 1'b0;
    end else if (rd_v_q) begin
      if (tag_match && !found_q) begin
        found_q   <= 1'b1;
      end
      if (!ent_valid && !inv_found_q) begin
        inv_found_q <= 1'b1;
      end
      if (ent_valid && (!min_seen_q || (stamp_rd_q < min_stamp_q))) begin
        min_seen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      if (tag_match && !found_q) begin
        hit_idx_q <= rd_idx_q;
      end
      if (!ent_valid && !inv_found_q) begin
        inv_idx_q <= rd_idx_q;
      end
      if (ent_valid && (!min_seen_q || (stamp_rd_q < min_stamp_q))) begin
        min_stamp_q <= stamp_rd_q;
        min_idx_q   <= rd_idx_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_hit_q    <= found_q;
      out_slot_q   <= SLOT_W'(wr_idx);
      out_sector_q <= found_q ? '0 : (SECTOR_W'(pstart_q) + blk_sh_q);
    end
  end

  assign status_o.out_free = !out_valid_q || rsp.ready;

  assign rsp.valid        = out_valid_q;
  assign rsp.hit          = out_hit_q;
  assign rsp.slot         = out_slot_q;
  assign rsp.fetch_sector = out_sector_q;

`ifndef ASSERT_OFF
  // No memory read may still be in flight when the entry is written back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !rd_v_q)
    else $error("commit overlaps the walk");

  // A new or changed device leaves no entry valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && dev_change) |=> (valid_q == '0) && (use_cnt_q == '0))
    else $error("device change did not invalidate the directory");

  // A reported hit points at a valid entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && found_q) |-> valid_q[hit_idx_q])
    else $error("hit on an invalid entry");

  // A result appears only after a commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit))
    else $error("result without commit");
`endif

endmodule

FILE: dv/lru_block_cache_directory_tb.sv
// Self-checking testbench for the LRU block cache directory: directed and random lookups.
module lru_block_cache_directory_tb;
  import lbcd_pkg::*;

  localparam int ENTRIES     = DEFAULT_ENTRIES;
  localparam int IDLE_LIMIT  = 3000;  // cycles with no transaction before giving up
  localparam int HOLD_CYCLES = 400;   // long output stall for the backpressure test
  localparam int TAIL_CYCLES = 40;    // idle wait after the last result before the final check
  localparam int WS_MAX      = 48;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] fetch_sector;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lbcd_req_if req_ch ();
  lbcd_rsp_if rsp_ch ();

  lru_block_cache_directory #(.ENTRIES(ENTRIES)) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Directory shadow used to work out each lookup
  logic [BLK_W-1:0]    dir_tag   [ENTRIES];
  logic [ENTRIES-1:0]  dir_valid = '0;
  logic [STAMP_W-1:0]  dir_stamp [ENTRIES];
  logic [STAMP_W-1:0]  use_count = '0;
  logic [DEV_W-1:0]    cur_dev   = '0;
  logic                dev_known = 1'b0;
  logic [PSTART_W-1:0] part_start = '0;
  logic [SHIFT_W-1:0]  blk_shift  = BLOCK_SHIFT_RESET;

  lookup_t lookup_q[$];  // lookups accepted, result not yet seen
  int err_count     = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_output   = 1'b0;
  int idle_cycles   = 0;

  // Clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Lookup, hit update and LRU fill on the shadow directory
  function automatic lookup_t predict_lookup(input logic [DEV_W-1:0] dev,
                                             input logic [BLK_W-1:0] blk);
    lookup_t res;
    int      i;
    int      victim;
    bit      found;
    res   = '0;
    found = 1'b0;
    // First request or new device: flush everything
    if (!dev_known || dev != cur_dev) begin
      dir_valid = '0;
      for (i = 0; i < ENTRIES; i++) dir_stamp[i] = '0;
      use_count = '0;
      cur_dev   = dev;
      dev_known = 1'b1;
    end
    for (i = 0; i < ENTRIES; i++) begin
      if (!found && dir_valid[i] && dir_tag[i] == blk) begin
        found        = 1'b1;
        use_count    = use_count + 1'b1;
        dir_stamp[i] = use_count;
        res.hit      = 1'b1;
        res.slot     = SLOT_W'(i);
      end
    end
    if (!found) begin
      // lowest empty slot, else oldest stamp (lowest index on ties)
      victim = 0;
      found  = 1'b0;
      for (i = 0; i < ENTRIES; i++) begin
        if (!found && !dir_valid[i]) begin
          victim = i;
          found  = 1'b1;
        end
      end
      if (!found) begin
        for (i = 1; i < ENTRIES; i++)
          if (dir_stamp[i] < dir_stamp[victim]) victim = i;
      end
      use_count         = use_count + 1'b1;
      dir_stamp[victim] = use_count;
      dir_tag[victim]   = blk;
      dir_valid[victim] = 1'b1;
      res.slot          = SLOT_W'(victim);
      res.fetch_sector  = SECTOR_W'(part_start) + (SECTOR_W'(blk) << blk_shift);
    end
    return res;
  endfunction

  // One request transaction; called and returns just after a falling edge
  task automatic send_request(input logic [DEV_W-1:0] dev, input logic [BLK_W-1:0] blk);
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk_i);
    req_ch.valid        = 1'b1;
    req_ch.dev_id       = dev;
    req_ch.block_number = blk;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    lookup_q.push_back(predict_lookup(dev, blk));
    @(negedge clk_i);
    req_ch.valid = 1'b0;
  endtask

  // Register write; only while nothing is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_PARTITION_START) part_start = data;
    else blk_shift = data[SHIFT_W-1:0];
  endtask

  task automatic wait_all_results();
    while (lookup_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // New setting for both registers, extremes often
  task automatic apply_random_config();
    logic [CFG_DATA_W-1:0] ps;
    logic [SHIFT_W-1:0]    sh;
    case ($urandom_range(0, 2))
      0:       ps = '0;
      1:       ps = '1;
      default: ps = $urandom();
    endcase
    case ($urandom_range(0, 2))
      0:       sh = '0;
      1:       sh = '1;
      default: sh = SHIFT_W'($urandom_range(0, 15));
    endcase
    write_reg(REG_PARTITION_START, ps);
    write_reg(REG_BLOCK_SHIFT, CFG_DATA_W'(sh));
  endtask

  // Output side: random stalls, plus one long hold on request
  initial begin
    int stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else if (hold_output) begin
        hold_output  = 1'b0;
        stall_left   = HOLD_CYCLES - 1;
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Result check against the oldest pending lookup
  always @(posedge clk_i) begin : check_results
    lookup_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (lookup_q.size() == 0) begin
        $error("result with no pending lookup: hit=%0b slot=%0d fetch_sector=%0h",
               rsp_ch.hit, rsp_ch.slot, rsp_ch.fetch_sector);
        err_count++;
      end else begin
        want = lookup_q.pop_front();
        if (rsp_ch.hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, rsp_ch.hit);
          err_count++;
        end
        if (rsp_ch.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, rsp_ch.slot);
          err_count++;
        end
        if (rsp_ch.fetch_sector !== want.fetch_sector) begin
          $error("fetch_sector: expected %0h, got %0h", want.fetch_sector,
                 rsp_ch.fetch_sector);
          err_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // First request, hits, device changes, field and register extremes
  task automatic test_directed_lookups();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_request(8'h00, 31'h0000_0000);
    send_request(8'h00, 31'h0000_0000);
    send_request(8'h00, 31'h7FFF_FFFF);
    send_request(8'h00, 31'h7FFF_FFFF);
    send_request(8'h00, 31'h0000_0001);
    send_request(8'hFF, 31'h0000_0000);
    send_request(8'hFF, 31'h7FFF_FFFF);
    send_request(8'h00, 31'h0000_0000);
    send_request(8'h55, 31'h2AAA_AAAA);
    send_request(8'hAA, 31'h5555_5555);
    wait_all_results();
    write_reg(REG_PARTITION_START, 32'hFFFF_FFFF);
    write_reg(REG_BLOCK_SHIFT, CFG_DATA_W'(4'hF));
    // largest possible sector, then a hit with nonzero settings
    send_request(8'hAA, 31'h7FFF_FFFF);
    send_request(8'hAA, 31'h7FFF_FFFF);
    send_request(8'hAA, 31'h5555_5555);
    wait_all_results();
    write_reg(REG_PARTITION_START, 32'h0000_0000);
    write_reg(REG_BLOCK_SHIFT, CFG_DATA_W'(4'h0));
    send_request(8'hAA, 31'h0000_0005);
    send_request(8'hAA, 31'h0000_0005);
    wait_all_results();
  endtask

  // Working-set traffic: hits, LRU evictions, occasional new device
  task automatic test_random_lookups(input int n_items, input int s_pct, input int r_pct);
    logic [BLK_W-1:0] work_set [WS_MAX];
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    int               ws_size;
    int               n;
    int               k;
    int               roll;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    dev = cur_dev;
    n   = 0;
    while (n < n_items) begin
      wait_all_results();
      apply_random_config();
      // below 32 mostly hits, above 32 forces evictions
      ws_size = $urandom_range(8, WS_MAX);
      for (k = 0; k < WS_MAX; k++)
        work_set[k] = k[0] ? BLK_W'($urandom()) : BLK_W'($urandom_range(0, 255));
      for (k = 0; k < 70 && n < n_items; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) dev = DEV_W'($urandom_range(0, 255));
        if (roll >= 85) blk = BLK_W'($urandom());
        else blk = work_set[$urandom_range(0, ws_size - 1)];
        send_request(dev, blk);
        n++;
      end
    end
  endtask

  // Long output stall while requests keep coming
  task automatic test_output_backpressure();
    int k;
    hold_output = 1'b1;
    for (k = 0; k < 10; k++) send_request(cur_dev, BLK_W'($urandom_range(0, 40)));
    wait_all_results();
  endtask

  // Bursts separated by a full drain
  task automatic test_sender_pause();
    int k;
    int b;
    for (b = 0; b < 2; b++) begin
      for (k = 0; k < 12; k++) send_request(cur_dev, BLK_W'($urandom_range(0, 40)));
      wait_all_results();
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_PARTITION_START;
    cfg_data_i          = '0;
    req_ch.valid        = 1'b0;
    req_ch.dev_id       = '0;
    req_ch.block_number = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_lookups();
    test_random_lookups(280, 27, 51);
    test_random_lookups(280, 51, 27);
    test_output_backpressure();
    test_random_lookups(270, 0, 0);
    test_sender_pause();

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0 && lookup_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: lru_block_cache_directory.f
design/lbcd_pkg.sv
design/lbcd_if.sv
design/lbcd_ctrl.sv
design/lbcd_datapath.sv
design/lru_block_cache_directory.sv
dv/lru_block_cache_directory_tb.sv
